// ----- rtl/h3_two_generation_bloom_filter_top_macros.svh -----
// Assertion macros for the two-generation Bloom filter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef H3_TWO_GENERATION_BLOOM_FILTER_TOP_MACROS_SVH
`define H3_TWO_GENERATION_BLOOM_FILTER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define H3BF_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("h3bf: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define H3BF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("h3bf: next-cycle check failed");

`endif

// ----- rtl/h3bf_pkg.sv -----
// Shared types and constants for the two-generation Bloom filter.
// No dependencies; imported by every module of the block.
package h3bf_pkg;

  // Parameter defaults
  localparam int FILTER_BITS_DEF  = 1024;
  localparam int NUM_HASHES_DEF   = 4;
  localparam int ADDRESS_BITS_DEF = 64;

  // Fixed field widths
  localparam int OPCODE_W   = 2;
  localparam int ADDR_W     = 64;
  localparam int SEED_IDX_W = 8;
  localparam int SEED_W     = 10;
  localparam int COUNT_W    = 11;

  // Seed table layout: one row of 64 seeds per hash
  localparam int SEED_STRIDE = 64;
  localparam int STRIDE_W    = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = 11'd2047;
  localparam logic [COUNT_W-1:0] THRESH_RESET = 11'd512;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SEED   = 2'd2;

  // Requests from the sequencer to the hash unit
  typedef struct packed {
    logic                  start;
    logic                  seed_we;
    logic [SEED_IDX_W-1:0] seed_idx;
    logic [SEED_W-1:0]     seed_val;
  } hash_req_t;

  // Write controls for the two bit arrays
  typedef struct packed {
    logic we_a;
    logic we_b;
    logic wr_bit;
  } bits_ctl_t;

endpackage

// ----- rtl/h3bf_hash.sv -----
// H3 hash unit: seed memory, shared XOR accumulator and index registers.
// Depends on h3bf_pkg. One seed is folded in per cycle.
module h3bf_hash #(
  parameter int FILTER_BITS  = h3bf_pkg::FILTER_BITS_DEF,
  parameter int NUM_HASHES   = h3bf_pkg::NUM_HASHES_DEF,
  parameter int ADDRESS_BITS = h3bf_pkg::ADDRESS_BITS_DEF,
  localparam int IDX_W = $clog2(FILTER_BITS),
  localparam int IH_W  = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  h3bf_pkg::hash_req_t       req,
  input  logic [h3bf_pkg::ADDR_W-1:0] addr,
  input  logic [IH_W-1:0]           idx_sel,
  output logic [IDX_W-1:0]          idx,
  output logic                      done
);
  import h3bf_pkg::*;

  localparam int SEED_DEPTH = NUM_HASHES * SEED_STRIDE;
  localparam int SA_W       = $clog2(SEED_DEPTH);
  localparam int RED_W      = 24;
  localparam logic [RED_W-1:0] FB_R = RED_W'(FILTER_BITS);

  logic [SEED_W-1:0]   seed_mem [SEED_DEPTH];
  logic [SEED_W-1:0]   seed_q_r;
  logic [SA_W-1:0]     seed_raddr;
  logic [ADDR_W-1:0]   addr_r;
  logic                busy_r;
  logic [IH_W-1:0]     h_r;
  logic [STRIDE_W-1:0] b_r;
  logic                rd_v_r;
  logic                rd_bit_r;
  logic                rd_last_r;
  logic [IH_W-1:0]     rd_h_r;
  logic [SEED_W-1:0]   acc_r;
  logic [SEED_W-1:0]   acc_x;
  logic [RED_W-1:0]    red;
  logic                done_r;
  logic [IDX_W-1:0]    idx_r [NUM_HASHES];
  logic                seed_wr_ok;
  logic                b_last;

  assign seed_raddr = SA_W'({h_r, b_r});
  assign seed_wr_ok = req.seed_we && ({3'b000, req.seed_idx} < 11'(SEED_DEPTH));
  assign b_last     = (b_r == STRIDE_W'(ADDRESS_BITS - 1));

  // Seed memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (seed_wr_ok) begin
      seed_mem[SA_W'(req.seed_idx)] <= req.seed_val;
    end
    seed_q_r <= seed_mem[seed_raddr];
  end

  // Fold in the returned seed and reduce the sum into the filter range
  always_comb begin
    acc_x = acc_r ^ (rd_bit_r ? seed_q_r : '0);
    red   = RED_W'(acc_x);
    for (int k = 6; k >= 0; k--) begin
      if (red >= (FB_R << k)) begin
        red = red - (FB_R << k);
      end
    end
  end

  // Walk hashes and address bits, then store each finished index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      h_r       <= '0;
      b_r       <= '0;
      rd_v_r    <= 1'b0;
      rd_last_r <= 1'b0;
      done_r    <= 1'b0;
      acc_r     <= '0;
    end else begin
      done_r    <= 1'b0;
      rd_v_r    <= busy_r;
      rd_last_r <= busy_r && b_last;
      if (req.start) begin
        busy_r <= 1'b1;
        h_r    <= '0;
        b_r    <= '0;
        acc_r  <= '0;
      end else if (busy_r) begin
        if (b_last) begin
          b_r <= '0;
          if (h_r == IH_W'(NUM_HASHES - 1)) begin
            busy_r <= 1'b0;
          end else begin
            h_r <= h_r + 1'b1;
          end
        end else begin
          b_r <= b_r + 1'b1;
        end
      end
      if (rd_v_r) begin
        if (rd_last_r) begin
          acc_r <= '0;
          if (rd_h_r == IH_W'(NUM_HASHES - 1)) begin
            done_r <= 1'b1;
          end
        end else begin
          acc_r <= acc_x;
        end
      end
    end
  end

  // Payload side of the read pipeline and the index registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      addr_r <= addr;
    end
    rd_bit_r <= addr_r[b_r];
    rd_h_r   <= h_r;
    if (rd_v_r && rd_last_r) begin
      idx_r[rd_h_r] <= red[IDX_W-1:0];
    end
  end

  assign idx  = idx_r[idx_sel];
  assign done = done_r;

endmodule

// ----- rtl/h3bf_bits.sv -----
// The two generation bit arrays, each a one-bit-wide memory.
// Depends on h3bf_pkg. Shared address for read and write, registered read.
module h3bf_bits #(
  parameter int FILTER_BITS = h3bf_pkg::FILTER_BITS_DEF,
  localparam int IDX_W = $clog2(FILTER_BITS)
) (
  input  logic                clk,
  input  h3bf_pkg::bits_ctl_t ctl,
  input  logic [IDX_W-1:0]    addr,
  output logic                rd_a,
  output logic                rd_b
);
  import h3bf_pkg::*;

  logic mem_a [FILTER_BITS];
  logic mem_b [FILTER_BITS];
  logic rd_a_r;
  logic rd_b_r;

  // Write either array, read both at the same address
  always_ff @(posedge clk) begin
    if (ctl.we_a) begin
      mem_a[addr] <= ctl.wr_bit;
    end
    if (ctl.we_b) begin
      mem_b[addr] <= ctl.wr_bit;
    end
    rd_a_r <= mem_a[addr];
    rd_b_r <= mem_b[addr];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

// ----- rtl/h3_two_generation_bloom_filter_top.sv -----
// Top level of the two-generation Bloom filter: sequencer, fill count, output register.
// Depends on h3bf_pkg, h3bf_hash, h3bf_bits and the assertion macro header.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_stall   | in_opcode, in_address, in_seed_index,
//          |           |                       | in_seed_value
//  out     | output    | out_valid / out_stall | out_hit, out_swapped
//  cfg     | input     | cfg_wr_en             | cfg_wr_data (fill threshold)
//
// An insert that misses the recent array first runs the hash unit, which reads one seed
// per cycle; then each index is read and checked in the probe and again in the insert.
// A swap clears the older array and, for an insert, adds one more insert pass.
// After reset both arrays are cleared; no item is taken then.
// A result waits in the output register while out_stall is high; the block holds the
// next result until that register frees and takes no item while one is in work.
`include "h3_two_generation_bloom_filter_top_macros.svh"

module h3_two_generation_bloom_filter_top #(
  parameter int FILTER_BITS  = h3bf_pkg::FILTER_BITS_DEF,
  parameter int NUM_HASHES   = h3bf_pkg::NUM_HASHES_DEF,
  parameter int ADDRESS_BITS = h3bf_pkg::ADDRESS_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [h3bf_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [h3bf_pkg::ADDR_W-1:0]     in_address,
  input  logic [h3bf_pkg::SEED_IDX_W-1:0] in_seed_index,
  input  logic [h3bf_pkg::SEED_W-1:0]     in_seed_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic                            out_swapped,
  input  logic                            cfg_wr_en,
  input  logic [h3bf_pkg::COUNT_W-1:0]    cfg_wr_data
);
  import h3bf_pkg::*;

  localparam int IDX_W = $clog2(FILTER_BITS);
  localparam int IH_W  = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HASH, S_PRD, S_PCHK, S_IRD, S_ICHK, S_SWCHK, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [IH_W-1:0]    h_r, h_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic               clr_both_r, clr_both_nxt;
  logic               recent_sel_r, recent_sel_nxt;
  logic [COUNT_W-1:0] fill_r, fill_nxt;
  logic [COUNT_W-1:0] thresh_r;
  logic               ins_r, ins_nxt;
  logic               pass_r, pass_nxt;
  logic               all_rec_r, all_rec_nxt;
  logic               all_old_r, all_old_nxt;
  logic               hit_r, hit_nxt;
  logic               swp_r, swp_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;
  logic               out_swp_r, out_swp_nxt;

  hash_req_t          hreq;
  logic               hash_done;
  logic [IDX_W-1:0]   hash_idx;
  bits_ctl_t          bctl;
  logic [IDX_W-1:0]   bits_addr;
  logic               rd_a, rd_b;
  logic               rd_rec, rd_old;
  logic               accept;
  logic               h_last;
  logic               out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign h_last   = (h_r == IH_W'(NUM_HASHES - 1));
  assign rd_rec   = recent_sel_r ? rd_b : rd_a;
  assign rd_old   = recent_sel_r ? rd_a : rd_b;
  assign out_free = !out_valid_r || !out_stall;

  // Hash unit requests
  always_comb begin
    hreq.start    = accept && ((in_opcode == OP_LOOKUP) || (in_opcode == OP_INSERT));
    hreq.seed_we  = accept && (in_opcode == OP_SEED);
    hreq.seed_idx = in_seed_index;
    hreq.seed_val = in_seed_value;
  end

  h3bf_hash #(
    .FILTER_BITS  (FILTER_BITS),
    .NUM_HASHES   (NUM_HASHES),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (hreq),
    .addr    (in_address),
    .idx_sel (h_r),
    .idx     (hash_idx),
    .done    (hash_done)
  );

  // Bit array address and writes: clear sweep or set of a recent bit
  always_comb begin
    bits_addr   = (state_r == S_CLR) ? clr_r : hash_idx;
    bctl.we_a   = 1'b0;
    bctl.we_b   = 1'b0;
    bctl.wr_bit = 1'b0;
    if (state_r == S_CLR) begin
      bctl.we_a = clr_both_r || !recent_sel_r;
      bctl.we_b = clr_both_r || recent_sel_r;
    end else if ((state_r == S_ICHK) && !rd_rec) begin
      bctl.we_a   = !recent_sel_r;
      bctl.we_b   = recent_sel_r;
      bctl.wr_bit = 1'b1;
    end
  end

  h3bf_bits #(
    .FILTER_BITS (FILTER_BITS)
  ) u_bits (
    .clk  (clk),
    .ctl  (bctl),
    .addr (bits_addr),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    h_nxt          = h_r;
    clr_nxt        = clr_r;
    clr_both_nxt   = clr_both_r;
    recent_sel_nxt = recent_sel_r;
    fill_nxt       = fill_r;
    ins_nxt        = ins_r;
    pass_nxt       = pass_r;
    all_rec_nxt    = all_rec_r;
    all_old_nxt    = all_old_r;
    hit_nxt        = hit_r;
    swp_nxt        = swp_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_hit_nxt    = out_hit_r;
    out_swp_nxt    = out_swp_r;

    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDX_W'(FILTER_BITS - 1)) begin
          clr_nxt = '0;
          if (clr_both_r) begin
            clr_both_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end else if (ins_r) begin
            h_nxt     = '0;
            pass_nxt  = 1'b1;
            state_nxt = S_IRD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          hit_nxt  = 1'b0;
          swp_nxt  = 1'b0;
          pass_nxt = 1'b0;
          ins_nxt  = (in_opcode == OP_INSERT);
          if (hreq.start) begin
            state_nxt = S_HASH;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          h_nxt       = '0;
          all_rec_nxt = 1'b1;
          all_old_nxt = 1'b1;
          state_nxt   = S_PRD;
        end
      end
      S_PRD: begin
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        all_rec_nxt = all_rec_r && rd_rec;
        all_old_nxt = all_old_r && rd_old;
        if (h_last) begin
          if (all_rec_nxt) begin
            hit_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            hit_nxt = all_old_nxt;
            if (ins_r) begin
              h_nxt     = '0;
              state_nxt = S_IRD;
            end else begin
              state_nxt = S_SWCHK;
            end
          end
        end else begin
          h_nxt     = h_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_IRD: begin
        state_nxt = S_ICHK;
      end
      S_ICHK: begin
        if (!rd_rec && (fill_r != COUNT_MAX)) begin
          fill_nxt = fill_r + 1'b1;
        end
        if (h_last) begin
          state_nxt = pass_r ? S_DONE : S_SWCHK;
        end else begin
          h_nxt     = h_r + 1'b1;
          state_nxt = S_IRD;
        end
      end
      S_SWCHK: begin
        if (fill_r >= thresh_r) begin
          recent_sel_nxt = !recent_sel_r;
          fill_nxt       = '0;
          swp_nxt        = 1'b1;
          clr_nxt        = '0;
          clr_both_nxt   = 1'b0;
          state_nxt      = S_CLR;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_r;
          out_swp_nxt   = swp_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, counters and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      h_r          <= '0;
      clr_r        <= '0;
      clr_both_r   <= 1'b1;
      recent_sel_r <= 1'b0;
      fill_r       <= '0;
      thresh_r     <= THRESH_RESET;
      ins_r        <= 1'b0;
      pass_r       <= 1'b0;
      swp_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      h_r          <= h_nxt;
      clr_r        <= clr_nxt;
      clr_both_r   <= clr_both_nxt;
      recent_sel_r <= recent_sel_nxt;
      fill_r       <= fill_nxt;
      ins_r        <= ins_nxt;
      pass_r       <= pass_nxt;
      swp_r        <= swp_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    all_rec_r <= all_rec_nxt;
    all_old_r <= all_old_nxt;
    hit_r     <= hit_nxt;
    out_hit_r <= out_hit_nxt;
    out_swp_r <= out_swp_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_swapped = out_swp_r;

  // Generation flips only together with a swap flag for the item in work
  `H3BF_ASSERT_IMPL(a_swap_flagged, (recent_sel_r != $past(recent_sel_r)), swp_r)
  // Hash completion is only seen while the sequencer waits for it
  `H3BF_ASSERT_IMPL(a_hash_done_state, hash_done, (state_r == S_HASH))
  // A finished result holds while the output register is still taken
  `H3BF_ASSERT_NEXT(a_done_waits, ((state_r == S_DONE) && out_valid && out_stall),
                    (state_r == S_DONE))

endmodule

// ----- dv/bloom_filter_checker.sv -----
// Checker for the two-generation Bloom filter: watches the item channels and the threshold port,
// keeps its own copy of the seeds, both bit arrays and the fill count, and compares every result.
// Depends on h3bf_pkg for field widths, opcodes and the default sizes.
`timescale 1ns / 100ps

module bloom_filter_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [h3bf_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic [h3bf_pkg::ADDR_W-1:0]     in_address,
  input  logic [h3bf_pkg::SEED_IDX_W-1:0] in_seed_index,
  input  logic [h3bf_pkg::SEED_W-1:0]     in_seed_value,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_hit,
  input  logic                            out_swapped,
  input  logic                            cfg_wr_en,
  input  logic [h3bf_pkg::COUNT_W-1:0]    cfg_wr_data,
  output int                              err_count,
  output int                              answers_pending,
  output int                              hits_seen,
  output int                              swaps_seen
);
  import h3bf_pkg::*;

  localparam int SEED_DEPTH = NUM_HASHES_DEF * SEED_STRIDE;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic hit;
    logic swapped;
  } answer_t;

  // Mirror of the filter state
  logic [SEED_W-1:0]          seeds [SEED_DEPTH];
  logic [FILTER_BITS_DEF-1:0] gen_bits [2];
  logic                       recent_sel;
  logic [COUNT_W-1:0]         fill_count;
  logic [COUNT_W-1:0]         fill_threshold;
  int                         probe_idx [NUM_HASHES_DEF];

  answer_t awaited_answers [$];
  int      mismatches;
  int      hit_total;
  int      swap_total;

  // XOR the seeds picked by the set key bits, one hash row at a time
  function automatic void hash_key(logic [ADDR_W-1:0] key);
    logic [SEED_W-1:0] acc;
    for (int h = 0; h < NUM_HASHES_DEF; h++) begin
      acc = '0;
      for (int b = 0; b < ADDRESS_BITS_DEF && b < ADDR_W; b++)
        if (key[b])
          acc ^= seeds[h * SEED_STRIDE + b];
      probe_idx[h] = int'(acc) % FILTER_BITS_DEF;
    end
  endfunction

  function automatic logic generation_holds(int g);
    for (int h = 0; h < NUM_HASHES_DEF; h++)
      if (!gen_bits[g][probe_idx[h]])
        return 1'b0;
    return 1'b1;
  endfunction

  // Set the missing recent bits; count each bit only when it first goes high
  function automatic void mark_recent();
    for (int h = 0; h < NUM_HASHES_DEF; h++)
      if (!gen_bits[recent_sel][probe_idx[h]]) begin
        gen_bits[recent_sel][probe_idx[h]] = 1'b1;
        if (fill_count < COUNT_MAX)
          fill_count = fill_count + 1'b1;
      end
  endfunction

  // Apply one item to the mirrored filter and return the answer it should give
  function automatic answer_t apply_to_filter(logic [OPCODE_W-1:0] op, logic [ADDR_W-1:0] key,
                                              logic [SEED_IDX_W-1:0] sidx,
                                              logic [SEED_W-1:0] sval);
    answer_t ans;
    int      older;
    ans = '0;
    case (op)
      OP_SEED: begin
        if (int'(sidx) < SEED_DEPTH)
          seeds[sidx] = sval;
      end
      OP_LOOKUP, OP_INSERT: begin
        hash_key(key);
        older = recent_sel ? 0 : 1;
        if (generation_holds(int'(recent_sel))) begin
          ans.hit = 1'b1;
        end else begin
          ans.hit = generation_holds(older);
          if (op == OP_INSERT)
            mark_recent();
          // Swap check runs on every recent miss, insert or not
          if (fill_count >= fill_threshold) begin
            gen_bits[older] = '0;
            recent_sel = ~recent_sel;
            fill_count = '0;
            ans.swapped = 1'b1;
            if (op == OP_INSERT)
              mark_recent();
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Track configuration, queue predicted answers, compare delivered ones
  always @(posedge clk) begin : watch_channels
    answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < SEED_DEPTH; i++)
        seeds[i] = '0;
      gen_bits[0] = '0;
      gen_bits[1] = '0;
      recent_sel = 1'b0;
      fill_count = '0;
      fill_threshold = THRESH_RESET;
      awaited_answers.delete();
      mismatches = 0;
      hit_total = 0;
      swap_total = 0;
    end else begin
      if (cfg_wr_en)
        fill_threshold = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (awaited_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result, nothing awaited: hit %0b swapped %0b",
                     $time, out_hit, out_swapped);
        end else begin
          want = awaited_answers.pop_front();
          if (out_hit !== want.hit || out_swapped !== want.swapped) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: result mismatch: hit exp %0b got %0b, swapped exp %0b got %0b",
                       $time, want.hit, out_hit, want.swapped, out_swapped);
          end
          if (out_hit === 1'b1)
            hit_total++;
          if (out_swapped === 1'b1)
            swap_total++;
        end
      end
      if (in_valid && !in_stall)
        awaited_answers.insert(awaited_answers.size(),
                               apply_to_filter(in_opcode, in_address, in_seed_index,
                                               in_seed_value));
    end
    err_count       <= mismatches;
    answers_pending <= awaited_answers.size();
    hits_seen       <= hit_total;
    swaps_seen      <= swap_total;
  end

endmodule

// ----- dv/testbench.sv -----
// Top of the Bloom filter testbench: clock, reset, item stimulus, stall patterns and watchdog.
// Depends on h3bf_pkg, the filter top level and bloom_filter_checker.
`timescale 1ns / 100ps

module testbench;
  import h3bf_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_IGNORED = 2'd3;
  localparam int SEED_DEPTH      = NUM_HASHES_DEF * SEED_STRIDE;
  localparam int RANDOM_ITEMS    = 270;
  localparam int PHASES          = 6;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int KEY_POOL_DEPTH  = 40;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [OPCODE_W-1:0]   in_opcode;
  logic [ADDR_W-1:0]     in_address;
  logic [SEED_IDX_W-1:0] in_seed_index;
  logic [SEED_W-1:0]     in_seed_value;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_hit;
  logic                  out_swapped;
  logic                  cfg_wr_en;
  logic [COUNT_W-1:0]    cfg_wr_data;

  int check_errors;
  int answers_pending;
  int hits_seen;
  int swaps_seen;

  // Sender bookkeeping
  logic           valid_q;
  int             burst_left;
  int             n_lookup, n_insert, n_seed, n_ignored, n_worked;
  logic [ADDR_W-1:0] key_pool [$];
  logic           hold_off_toggle = 1'b0;
  int             idle_cycles;

  always #4 clk = ~clk;

  h3_two_generation_bloom_filter_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_address    (in_address),
    .in_seed_index (in_seed_index),
    .in_seed_value (in_seed_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_swapped   (out_swapped),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  bloom_filter_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_address      (in_address),
    .in_seed_index   (in_seed_index),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_swapped     (out_swapped),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .err_count       (check_errors),
    .answers_pending (answers_pending),
    .hits_seen       (hits_seen),
    .swaps_seen      (swaps_seen)
  );

  // Offer one item, hold it until taken, then maybe close the burst with a gap
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [ADDR_W-1:0] key,
                           input logic [SEED_IDX_W-1:0] sidx, input logic [SEED_W-1:0] sval);
    int gap;
    in_opcode     <= op;
    in_address    <= key;
    in_seed_index <= sidx;
    in_seed_value <= sval;
    in_valid      <= 1'b1;
    valid_q = 1'b1;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    case (op)
      OP_LOOKUP: n_lookup++;
      OP_INSERT: n_insert++;
      OP_SEED:   n_seed++;
      default:   n_ignored++;
    endcase
    if (op != OP_IGNORED)
      n_worked++;
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      valid_q = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every awaited answer is back
  task automatic wait_idle();
    if (valid_q) begin
      in_valid <= 1'b0;
      valid_q = 1'b0;
    end
    @(posedge clk);
    while (answers_pending != 0)
      @(posedge clk);
  endtask

  task automatic write_threshold(input logic [COUNT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Dense random keys mostly, with single-bit and single-hole keys mixed in
  function automatic logic [ADDR_W-1:0] random_key();
    logic [ADDR_W-1:0] one_bit;
    one_bit = 64'd1 << $urandom_range(0, ADDR_W - 1);
    case ($urandom_range(0, 9))
      0:       return one_bit;
      1:       return ~one_bit;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Inserts build a pool of keys; lookups mostly revisit it so hits and swaps get exercised
  task automatic send_random_item();
    logic [ADDR_W-1:0]     key;
    logic [SEED_IDX_W-1:0] sidx;
    logic [SEED_W-1:0]     sval;
    int                    pick;
    pick = $urandom_range(0, 99);
    key  = random_key();
    sidx = SEED_IDX_W'($urandom_range(0, 255));
    sval = SEED_W'($urandom_range(0, 1023));
    if (pick < 8) begin
      send_item(OP_IGNORED, key, sidx, sval);
    end else if (pick < 18) begin
      send_item(OP_SEED, key, sidx, sval);
    end else if (pick < 55) begin
      if (key_pool.size() > 0 && $urandom_range(0, 3) == 0) begin
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else begin
        key_pool.insert(key_pool.size(), key);
        if (key_pool.size() > KEY_POOL_DEPTH)
          void'(key_pool.pop_front());
      end
      send_item(OP_INSERT, key, sidx, sval);
    end else begin
      if (key_pool.size() > 0 && $urandom_range(0, 9) < 6)
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      send_item(OP_LOOKUP, key, sidx, sval);
    end
  endtask

  // Receiver: stretches of no stall, light stall and heavy stall, plus one long hold-off
  initial begin : receiver
    int   span;
    int   mode;
    int   hold_left;
    logic toggle_seen;
    out_stall   = 1'b0;
    hold_left   = 0;
    toggle_seen = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(30, 500);
      repeat (span) begin
        @(posedge clk);
        if (hold_off_toggle != toggle_seen) begin
          toggle_seen = hold_off_toggle;
          hold_left   = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_stall <= 1'b1;
        end else begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 30);
            default: out_stall <= ($urandom_range(0, 99) < 80);
          endcase
        end
      end
    end
  end

  // Watchdog: end the run if no item moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", idle_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [SEED_W-1:0]  sval;
    logic [COUNT_W-1:0] thr;
    int                 per_phase;
    int                 phase_target;
    logic               hold_off_done;
    in_valid      = 1'b0;
    in_opcode     = OP_LOOKUP;
    in_address    = '0;
    in_seed_index = '0;
    in_seed_value = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    rst_n         = 1'b0;
    idle_cycles   = 0;
    valid_q       = 1'b0;
    burst_left    = $urandom_range(1, 16);
    n_lookup      = 0;
    n_insert      = 0;
    n_seed        = 0;
    n_ignored     = 0;
    n_worked      = 0;
    hold_off_done = 1'b0;
    per_phase     = RANDOM_ITEMS / PHASES;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Zero threshold: every recent miss swaps. Key zero reads no seed, and all four
    // hashes land on index zero, so the insert counts that bit once.
    write_threshold('0);
    send_item(OP_LOOKUP, '0, '0, '0);
    send_item(OP_INSERT, '0, '0, '0);
    send_item(OP_LOOKUP, '0, '0, '0);
    send_item(OP_IGNORED, '1, '1, '1);

    // Load the whole seed table before any key with set bits goes in
    for (int i = 0; i < SEED_DEPTH; i++) begin
      if (i == 0)
        sval = '0;
      else if (i == SEED_DEPTH - 1)
        sval = '1;
      else
        sval = SEED_W'($urandom_range(0, 1023));
      send_item(OP_SEED, random_key(), SEED_IDX_W'(i), sval);
    end

    // Threshold 1024: inserts only fill the recent array, no swaps
    wait_idle();
    write_threshold(11'd1024);
    send_item(OP_INSERT, '1, '0, '0);
    send_item(OP_INSERT, 64'h8000_0000_0000_0000, '0, '0);
    send_item(OP_INSERT, 64'd1, '0, '0);
    send_item(OP_LOOKUP, '1, '0, '0);
    send_item(OP_INSERT, 64'd1, '0, '0);
    send_item(OP_LOOKUP, 64'h5555_5555_5555_5555, '0, '0);

    // Low threshold already passed: a lookup-only miss swaps without inserting,
    // then the earlier key is found only in the older array
    wait_idle();
    write_threshold(11'd3);
    send_item(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0, '0);
    send_item(OP_LOOKUP, '1, '0, '0);
    send_item(OP_INSERT, 64'h0123_4567_89AB_CDEF, '0, '0);

    // Random phases, one threshold each, written with the filter drained
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       thr = '0;
        1:       thr = 11'd1024;
        2:       thr = THRESH_RESET;
        3:       thr = COUNT_W'($urandom_range(1, 40));
        4:       thr = COUNT_W'($urandom_range(41, 300));
        default: thr = COUNT_W'($urandom_range(1, 12));
      endcase
      wait_idle();
      write_threshold(thr);
      phase_target = n_worked + per_phase;
      while (n_worked < phase_target) begin
        // Long receiver hold-off while items keep coming, so the input backs up
        if (phase == 3 && !hold_off_done && n_worked >= phase_target - per_phase / 2) begin
          hold_off_toggle <= ~hold_off_toggle;
          hold_off_done = 1'b1;
        end
        send_random_item();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d lookups, %0d inserts, %0d seed writes, %0d ignored opcodes",
             n_lookup, n_insert, n_seed, n_ignored);
    $display("over thresholds 0 to 1024: %0d hits and %0d generation swaps checked",
             hits_seen, swaps_seen);
    if (check_errors == 0 && answers_pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
